>>> design/gbncc_pkg.sv
// Package: types and constants shared by the go-back-N congestion control block.
`timescale 1ns / 1ps

package gbncc_pkg;

    // Field widths
    localparam int SEQ_W   = 20;   // ACK sequence number
    localparam int CNT_W   = 21;   // packet index and packet count
    localparam int WIN_W   = 16;   // congestion window and threshold
    localparam int CFG_A_W = 2;    // configuration register index

    // Transfer size limit and window saturation value
    localparam logic [CNT_W-1:0] MAX_PACKETS = CNT_W'(1048576);
    localparam logic [WIN_W-1:0] WIN_MAX     = {WIN_W{1'b1}};

    // Reset values of the configuration registers
    localparam logic [CNT_W-1:0] TOTAL_RST   = CNT_W'(1);
    localparam logic [WIN_W-1:0] SSTHRESH_RST = WIN_W'(32767);

    // Duplicate ACK threshold for fast retransmit
    localparam logic [1:0] DUP_LIMIT = 2'd3;

    // Event kinds
    localparam logic CMD_ACK     = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_TOTAL_PACKETS    = CFG_A_W'(0);
    localparam logic [CFG_A_W-1:0] CFG_INITIAL_SSTHRESH = CFG_A_W'(1);

    // Congestion control phase
    typedef enum logic [1:0] {
        PH_SLOW  = 2'd0,
        PH_AVOID = 2'd1,
        PH_RECOV = 2'd2
    } t_phase;

    // Input event word
    typedef struct packed {
        logic             cmd;
        logic [SEQ_W-1:0] ack_seqno;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [CNT_W-1:0] send_from;
        logic [CNT_W-1:0] send_to;
        logic             retransmit;
        logic [WIN_W-1:0] window_size;
        logic [WIN_W-1:0] threshold;
        logic [1:0]       phase;
        logic             finished;
    } t_out_word;

    // Configuration write word
    typedef struct packed {
        logic [CFG_A_W-1:0] index;
        logic [CNT_W-1:0]   data;
    } t_cfg_word;

endpackage

>>> design/gbncc_if.sv
// Interfaces: valid/ready channels for events, results and configuration writes.
`timescale 1ns / 1ps

interface gbncc_in_if import gbncc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gbncc_out_if import gbncc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gbncc_cfg_if import gbncc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/go_back_n_congestion_control.sv
// Go-back-N sender window with Reno-style congestion control: top level.
//
// Each input word is one event (an arriving cumulative ACK, or a retransmission
// timeout) and yields exactly one result word: the packet range to send now, a
// retransmit flag, and the window, threshold and phase after the event. An
// event is processed combinationally: the state registers and the result
// register load together at the accepting edge, so one event per clock is
// sustained while the result side keeps taking words; the result appears in
// the cycle after its event. The input stalls only while a result is held in
// the output register and the sink is not ready. Configuration writes
// (transfer size, initial slow start threshold) are always accepted; a
// threshold write also loads the live threshold. Write them while no event
// is in flight.
`timescale 1ns / 1ps

module go_back_n_congestion_control
    import gbncc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gbncc_in_if.sink             i_in,
    gbncc_out_if.source          o_out,
    gbncc_cfg_if.sink            i_cfg
);

    // Configuration registers
    logic [CNT_W-1:0] r_total;
    logic [WIN_W-1:0] r_init_thr;

    // Protocol state
    t_phase           r_phase,    n_phase;
    logic [WIN_W-1:0] r_window,   n_window;
    logic [WIN_W-1:0] r_thr,      n_thr;
    logic [CNT_W-1:0] r_base,     n_base;
    logic [CNT_W-1:0] r_next,     n_next;
    logic [SEQ_W-1:0] r_prev_ack, n_prev_ack;
    logic             r_have_ack, n_have_ack;
    logic [1:0]       r_dup,      n_dup;
    logic [WIN_W-1:0] r_cnt,      n_cnt;
    logic             r_done,     n_done;

    // Result register
    logic             r_out_valid;
    t_out_word        r_out;
    t_out_word        n_out;

    logic             in_acc;
    logic             cfg_acc;
    logic             retx;
    logic [WIN_W-1:0] half_win;
    logic [WIN_W-1:0] win_inc;
    logic [WIN_W-1:0] cnt_inc;
    logic [1:0]       dup_inc;
    logic [CNT_W-1:0] eff_total;
    logic [CNT_W:0]   lim_sum;
    logic [CNT_W-1:0] lim;
    logic [CNT_W-1:0] send_from;
    logic [CNT_W-1:0] send_to;

    // Handshakes: take an event whenever the result register is free or drains
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Shared arithmetic
    assign half_win  = r_window >> 1;
    assign win_inc   = (r_window == WIN_MAX) ? WIN_MAX : r_window + WIN_W'(1);
    assign cnt_inc   = r_cnt + WIN_W'(1);
    assign dup_inc   = (r_dup == DUP_LIMIT) ? DUP_LIMIT : r_dup + 2'd1;
    assign eff_total = (r_total > MAX_PACKETS) ? MAX_PACKETS : r_total;

    // Next state for one event
    always_comb begin
        n_phase    = r_phase;
        n_window   = r_window;
        n_thr      = r_thr;
        n_base     = r_base;
        n_prev_ack = r_prev_ack;
        n_have_ack = r_have_ack;
        n_dup      = r_dup;
        n_cnt      = r_cnt;
        n_done     = r_done;
        retx       = 1'b0;
        if (!r_done) begin
            priority if (i_in.data.cmd == CMD_TIMEOUT) begin
                n_dup    = 2'd0;
                n_thr    = half_win;
                n_window = WIN_W'(1);
                n_phase  = PH_SLOW;
                n_cnt    = '0;
                retx     = 1'b1;
            end else if (r_have_ack && (i_in.data.ack_seqno == r_prev_ack)) begin
                // duplicate ACK
                if (r_phase == PH_RECOV) begin
                    n_thr    = half_win;
                    n_window = half_win + WIN_W'(1);
                    n_dup    = 2'd0;
                    retx     = 1'b1;
                end else begin
                    n_dup = dup_inc;
                    if (dup_inc == DUP_LIMIT) begin
                        n_thr    = half_win;
                        n_window = half_win + WIN_W'(3);
                        n_phase  = PH_RECOV;
                        retx     = 1'b1;
                    end
                end
            end else if ({1'b0, i_in.data.ack_seqno} == r_total - CNT_W'(1)) begin
                n_done = 1'b1;
            end else begin
                // new ACK
                n_dup      = 2'd0;
                n_prev_ack = i_in.data.ack_seqno;
                n_have_ack = 1'b1;
                n_base     = {1'b0, i_in.data.ack_seqno} + CNT_W'(1);
                unique case (r_phase)
                    PH_SLOW: begin
                        n_window = win_inc;
                        if (win_inc >= r_thr) begin
                            n_phase = PH_AVOID;
                            n_cnt   = '0;
                        end
                    end
                    PH_AVOID: begin
                        if (cnt_inc >= r_window) begin
                            n_window = win_inc;
                            n_cnt    = '0;
                        end else begin
                            n_cnt = cnt_inc;
                        end
                    end
                    default: begin
                        n_window = (r_thr == '0) ? WIN_W'(1) : r_thr;
                        n_phase  = PH_AVOID;
                        n_cnt    = '0;
                    end
                endcase
            end
        end

        // send range: restart at the base on retransmit, then fill the window
        send_from = retx ? n_base : r_next;
        lim_sum   = {1'b0, n_base} + {{(CNT_W + 1 - WIN_W){1'b0}}, n_window};
        lim       = (lim_sum > {1'b0, eff_total}) ? eff_total : lim_sum[CNT_W-1:0];
        send_to   = send_from;
        if (!n_done && (lim > send_from)) begin
            send_to = lim;
        end
        n_next = send_to;
    end

    // Result word
    always_comb begin
        n_out.send_from   = send_from;
        n_out.send_to     = send_to;
        n_out.retransmit  = retx;
        n_out.window_size = n_window;
        n_out.threshold   = n_thr;
        n_out.phase       = n_phase;
        n_out.finished    = n_done;
    end

    // State and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= TOTAL_RST;
            r_init_thr <= SSTHRESH_RST;
            r_phase    <= PH_SLOW;
            r_window   <= WIN_W'(1);
            r_thr      <= SSTHRESH_RST;
            r_base     <= '0;
            r_next     <= '0;
            r_prev_ack <= '0;
            r_have_ack <= 1'b0;
            r_dup      <= 2'd0;
            r_cnt      <= '0;
            r_done     <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase    <= n_phase;
                r_window   <= n_window;
                r_thr      <= n_thr;
                r_base     <= n_base;
                r_next     <= n_next;
                r_prev_ack <= n_prev_ack;
                r_have_ack <= n_have_ack;
                r_dup      <= n_dup;
                r_cnt      <= n_cnt;
                r_done     <= n_done;
            end
            if (cfg_acc) begin
                unique case (i_cfg.data.index)
                    CFG_TOTAL_PACKETS: begin
                        r_total <= i_cfg.data.data;
                    end
                    CFG_INITIAL_SSTHRESH: begin
                        r_init_thr <= i_cfg.data.data[WIN_W-1:0];
                        r_thr      <= i_cfg.data.data[WIN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result register: valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register: word
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= n_out;
        end
    end

`ifndef NO_ASSERTIONS
    // window never collapses to zero
    a_window_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_window != '0)
        else $error("congestion window is zero");

    // a full duplicate count only exists in fast recovery
    a_dup_in_recov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dup == DUP_LIMIT) |-> (r_phase == PH_RECOV))
        else $error("three duplicates outside fast recovery");

    // finished is sticky
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("finished flag dropped");

    // a retransmission starts at the current window base
    a_retx_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.retransmit) |-> (r_out.send_from == r_base))
        else $error("retransmission does not start at the window base");

    // range never runs backwards
    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.send_to >= r_out.send_from))
        else $error("send range end below its start");

    // initial threshold register only moves on a configuration write
    a_init_thr_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(cfg_acc) && $past(i_rst_n) |-> $stable(r_init_thr))
        else $error("initial threshold changed without a write");
`endif

endmodule

>>> bench/go_back_n_congestion_control_tb.sv
// Testbench: go-back-N congestion control block checked against a cycle-free window predictor.
`timescale 1ns / 1ps

module go_back_n_congestion_control_tb;
    import gbncc_pkg::*;

    // Register indexes with no register behind them
    localparam logic [CFG_A_W-1:0] CFG_SPARE_2 = CFG_A_W'(2);
    localparam logic [CFG_A_W-1:0] CFG_SPARE_3 = CFG_A_W'(3);

    typedef enum logic [1:0] {
        STEP_EVENT,
        STEP_CFG,
        STEP_SETTLE
    } t_step_kind;

    typedef struct {
        t_step_kind kind;
        t_in_word   ev;
        t_cfg_word  cfg;
    } t_stim_step;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    gbncc_in_if  in_if ();
    gbncc_out_if out_if ();
    gbncc_cfg_if cfg_if ();

    go_back_n_congestion_control u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Sender state mirrored by the predictor
    t_phase           st_phase        = PH_SLOW;
    logic [WIN_W-1:0] cwnd            = WIN_W'(1);
    logic [WIN_W-1:0] ssthresh        = SSTHRESH_RST;
    logic [CNT_W-1:0] base_seq        = '0;
    logic [CNT_W-1:0] next_seq        = '0;
    logic [SEQ_W-1:0] last_ack        = '0;
    logic             ack_seen        = 1'b0;
    logic [1:0]       dup_acks        = 2'd0;
    logic [WIN_W-1:0] acked_in_window = '0;
    logic             xfer_done       = 1'b0;
    logic [CNT_W-1:0] pkt_total       = TOTAL_RST;

    t_stim_step  event_plan[$];
    t_out_word   pending_results[$];
    int unsigned fail_count = 0;

    // Plan-time bookkeeping
    logic [CNT_W-1:0] plan_total = TOTAL_RST;
    logic [SEQ_W-1:0] flow_ack   = '0;

    // Driver and monitor state
    t_stim_step  cur_step;
    bit          have_step     = 1'b0;
    int unsigned hold_cycles   = 0;
    int unsigned settle_cycles = 0;
    int unsigned stall_cycles  = 0;
    bit          in_burst      = 1'b0;
    bit          out_burst     = 1'b0;

    // Window saturates at the top and never drops to zero
    function automatic logic [WIN_W-1:0] clamp_window(logic [WIN_W:0] w);
        if (w > {1'b0, WIN_MAX}) return WIN_MAX;
        if (w == '0) return WIN_W'(1);
        return w[WIN_W-1:0];
    endfunction

    // Apply one event to the mirrored state and return the word it should produce
    function automatic t_out_word next_send_window(t_in_word ev);
        t_out_word        res;
        logic             retx;
        logic [CNT_W-1:0] eff_total;
        logic [CNT_W-1:0] last_seq;
        logic [CNT_W-1:0] from_seq;
        logic [CNT_W:0]   lim;
        retx      = 1'b0;
        eff_total = (pkt_total > MAX_PACKETS) ? MAX_PACKETS : pkt_total;
        last_seq  = pkt_total - 1'b1;
        if (!xfer_done) begin
            if (ev.cmd == CMD_TIMEOUT) begin
                dup_acks        = 2'd0;
                ssthresh        = cwnd >> 1;
                cwnd            = WIN_W'(1);
                st_phase        = PH_SLOW;
                acked_in_window = '0;
                retx            = 1'b1;
            end else if (ack_seen && ev.ack_seqno == last_ack) begin
                // duplicate ACK
                if (st_phase == PH_RECOV) begin
                    ssthresh = cwnd >> 1;
                    cwnd     = clamp_window({1'b0, ssthresh} + 1'b1);
                    dup_acks = 2'd0;
                    retx     = 1'b1;
                end else begin
                    if (dup_acks < DUP_LIMIT) dup_acks = dup_acks + 1'b1;
                    if (dup_acks == DUP_LIMIT) begin
                        ssthresh = cwnd >> 1;
                        cwnd     = clamp_window({1'b0, ssthresh} + 2'd3);
                        st_phase = PH_RECOV;
                        retx     = 1'b1;
                    end
                end
            end else if (CNT_W'(ev.ack_seqno) == last_seq) begin
                xfer_done = 1'b1;
            end else begin
                // new ACK slides the base
                dup_acks = 2'd0;
                last_ack = ev.ack_seqno;
                ack_seen = 1'b1;
                base_seq = CNT_W'(ev.ack_seqno) + 1'b1;
                case (st_phase)
                    PH_SLOW: begin
                        cwnd = clamp_window({1'b0, cwnd} + 1'b1);
                        if (cwnd >= ssthresh) begin
                            st_phase        = PH_AVOID;
                            acked_in_window = '0;
                        end
                    end
                    PH_AVOID: begin
                        acked_in_window = acked_in_window + 1'b1;
                        if (acked_in_window >= cwnd) begin
                            cwnd            = clamp_window({1'b0, cwnd} + 1'b1);
                            acked_in_window = '0;
                        end
                    end
                    default: begin
                        cwnd            = clamp_window({1'b0, ssthresh});
                        st_phase        = PH_AVOID;
                        acked_in_window = '0;
                    end
                endcase
            end
        end

        if (retx) next_seq = base_seq;
        from_seq    = next_seq;
        res.send_to = next_seq;
        if (!xfer_done) begin
            lim = {1'b0, base_seq} + cwnd;
            if (lim > {1'b0, eff_total}) lim = {1'b0, eff_total};
            if (lim > {1'b0, from_seq}) res.send_to = lim[CNT_W-1:0];
            next_seq = res.send_to;
        end
        res.send_from   = from_seq;
        res.retransmit  = retx;
        res.window_size = cwnd;
        res.threshold   = ssthresh;
        res.phase       = st_phase;
        res.finished    = xfer_done;
        return res;
    endfunction

    function automatic void load_register(t_cfg_word w);
        if (w.index == CFG_TOTAL_PACKETS) pkt_total = w.data;
        else if (w.index == CFG_INITIAL_SSTHRESH) ssthresh = w.data[WIN_W-1:0];
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Plan building; the last sequence is dodged unless the transfer may finish
    task automatic add_ack(logic [SEQ_W-1:0] seq, bit may_finish);
        t_stim_step s;
        if (!may_finish && CNT_W'(seq) == CNT_W'(plan_total - 1'b1)) seq = seq + 1'b1;
        s.kind         = STEP_EVENT;
        s.ev.cmd       = CMD_ACK;
        s.ev.ack_seqno = seq;
        s.cfg          = '0;
        event_plan.insert(event_plan.size(), s);
    endtask

    task automatic add_timeout();
        t_stim_step s;
        s.kind         = STEP_EVENT;
        s.ev.cmd       = CMD_TIMEOUT;
        s.ev.ack_seqno = SEQ_W'($urandom());
        s.cfg          = '0;
        event_plan.insert(event_plan.size(), s);
    endtask

    task automatic add_cfg(logic [CFG_A_W-1:0] idx, logic [CNT_W-1:0] value);
        t_stim_step s;
        s.kind     = STEP_CFG;
        s.ev       = '0;
        s.cfg.index = idx;
        s.cfg.data  = value;
        event_plan.insert(event_plan.size(), s);
        if (idx == CFG_TOTAL_PACKETS) plan_total = value;
    endtask

    task automatic add_settle();
        t_stim_step s;
        s.kind = STEP_SETTLE;
        s.ev   = '0;
        s.cfg  = '0;
        event_plan.insert(event_plan.size(), s);
    endtask

    // Mostly an advancing ACK stream, with duplicate runs, timeouts, stale ACKs and noise
    task automatic add_flow(int unsigned n_items);
        int unsigned pick;
        for (int unsigned k = 0; k < n_items; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                flow_ack = flow_ack + SEQ_W'($urandom_range(1, 4));
                add_ack(flow_ack, 1'b0);
            end else if (pick < 70) begin
                repeat ($urandom_range(1, 4)) add_ack(flow_ack, 1'b0);
            end else if (pick < 78) begin
                add_timeout();
            end else if (pick < 90) begin
                add_ack(flow_ack - SEQ_W'($urandom_range(1, 30)), 1'b0);
            end else begin
                add_ack(SEQ_W'($urandom()), 1'b0);
            end
        end
    endtask

    // Event and config driver
    always @(posedge i_clk) begin : drive_events
        logic nxt_in_valid;
        logic nxt_cfg_valid;
        nxt_in_valid  = in_if.valid;
        nxt_cfg_valid = cfg_if.valid;
        if (!i_rst_n) begin
            nxt_in_valid  = 1'b0;
            nxt_cfg_valid = 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                pending_results.insert(pending_results.size(),
                                       next_send_window(in_if.data));
                nxt_in_valid = 1'b0;
            end
            if (cfg_if.valid && cfg_if.ready) begin
                load_register(cfg_if.data);
                nxt_cfg_valid = 1'b0;
            end
            if (!nxt_in_valid && !nxt_cfg_valid) begin
                if (!have_step && event_plan.size() > 0) begin
                    cur_step      = event_plan.pop_front();
                    have_step     = 1'b1;
                    settle_cycles = 0;
                    if ($urandom_range(0, 49) == 0) in_burst = !in_burst;
                    hold_cycles = (in_burst || cur_step.kind == STEP_SETTLE) ?
                                  0 : $urandom_range(0, 5);
                end
                if (have_step) begin
                    if (hold_cycles > 0) begin
                        hold_cycles--;
                    end else begin
                        case (cur_step.kind)
                            STEP_EVENT: begin
                                in_if.data   <= cur_step.ev;
                                nxt_in_valid = 1'b1;
                                have_step    = 1'b0;
                            end
                            STEP_CFG: begin
                                cfg_if.data   <= cur_step.cfg;
                                nxt_cfg_valid = 1'b1;
                                have_step     = 1'b0;
                            end
                            default: begin
                                // hold off until every result is back, then a few quiet cycles
                                if (pending_results.size() != 0) settle_cycles = 0;
                                else if (settle_cycles == 3) have_step = 1'b0;
                                else settle_cycles++;
                            end
                        endcase
                    end
                end
            end
        end
        in_if.valid  <= nxt_in_valid;
        cfg_if.valid <= nxt_cfg_valid;
    end

    // Result monitor with random back-pressure
    always @(posedge i_clk) begin : watch_results
        logic      nxt_ready;
        t_out_word want;
        nxt_ready = out_if.ready;
        if (!i_rst_n) begin
            nxt_ready = 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result word with no prediction pending");
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("send_from", want.send_from, out_if.data.send_from);
                    check_field("send_to", want.send_to, out_if.data.send_to);
                    check_field("retransmit", want.retransmit, out_if.data.retransmit);
                    check_field("window_size", want.window_size, out_if.data.window_size);
                    check_field("threshold", want.threshold, out_if.data.threshold);
                    check_field("phase", want.phase, out_if.data.phase);
                    check_field("finished", want.finished, out_if.data.finished);
                end
                if ($urandom_range(0, 49) == 0) out_burst = !out_burst;
                stall_cycles = out_burst ? 0 : $urandom_range(0, 5);
            end else if (stall_cycles > 0) begin
                stall_cycles--;
            end
            nxt_ready = (stall_cycles == 0);
        end
        out_if.ready <= nxt_ready;
    end

    // Stimulus plan, reset and end of run
    initial begin : run_plan
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        out_if.ready = 1'b0;

        // Reset settings (one packet, so ACK 0 is dodged): first event reports the window
        add_timeout();
        add_ack(SEQ_W'(7), 1'b0);
        repeat (3) add_ack(SEQ_W'(7), 1'b0);
        add_ack(SEQ_W'(7), 1'b0);
        add_ack(SEQ_W'(3), 1'b0);
        add_ack({SEQ_W{1'b1}}, 1'b0);
        add_timeout();
        add_settle();

        // Small transfer: slow start ramp, fast retransmit, recovery, stale ACK
        add_cfg(CFG_TOTAL_PACKETS, CNT_W'(40));
        add_cfg(CFG_INITIAL_SSTHRESH, {5'b10101, 16'd4});
        for (int unsigned k = 0; k < 4; k++) add_ack(SEQ_W'(k), 1'b0);
        add_timeout();
        add_ack(SEQ_W'(4), 1'b0);
        repeat (3) add_ack(SEQ_W'(4), 1'b0);
        add_ack(SEQ_W'(4), 1'b0);
        add_ack(SEQ_W'(9), 1'b0);
        add_ack(SEQ_W'(2), 1'b0);
        add_settle();

        // Random traffic over several settings
        add_cfg(CFG_TOTAL_PACKETS, CNT_W'(1000));
        add_cfg(CFG_INITIAL_SSTHRESH, CNT_W'(8));
        flow_ack = '0;
        add_flow(300);
        add_settle();

        // Empty transfer, threshold of one
        add_cfg(CFG_TOTAL_PACKETS, '0);
        add_cfg(CFG_INITIAL_SSTHRESH, {5'b01010, 16'd1});
        add_flow(150);
        add_settle();

        // Largest legal transfer, ACKs near the top of the sequence space
        add_cfg(CFG_TOTAL_PACKETS, MAX_PACKETS);
        add_cfg(CFG_INITIAL_SSTHRESH, {5'b00000, 16'hFFFF});
        flow_ack = SEQ_W'(20'hFFE00);
        add_flow(300);
        add_settle();

        // Total beyond the ACK range; writes to indexes with no register
        add_cfg(CFG_SPARE_2, CNT_W'($urandom()));
        add_cfg(CFG_SPARE_3, CNT_W'($urandom()));
        add_cfg(CFG_TOTAL_PACKETS, {CNT_W{1'b1}});
        add_cfg(CFG_INITIAL_SSTHRESH, {5'b11111, 16'd16});
        add_flow(150);
        add_timeout();
        add_settle();

        // Window at the top: enter fast recovery, raise the threshold to the maximum,
        // then the next new ACK loads the full window and avoidance runs at that size
        add_ack(SEQ_W'(1000), 1'b0);
        add_ack(SEQ_W'(1001), 1'b0);
        repeat (3) add_ack(SEQ_W'(1001), 1'b0);
        add_settle();
        add_cfg(CFG_INITIAL_SSTHRESH, {5'b11111, 16'hFFFF});
        for (int unsigned k = 0; k < 20; k++) add_ack(SEQ_W'(k + 1002), 1'b0);
        add_timeout();
        add_settle();

        // Final transfer: random traffic, then the last ACK and events after finish
        add_cfg(CFG_TOTAL_PACKETS, CNT_W'(200));
        add_cfg(CFG_INITIAL_SSTHRESH, CNT_W'(12));
        flow_ack = '0;
        add_flow(300);
        for (int unsigned k = 150; k < 200; k++) add_ack(SEQ_W'(k), 1'b1);
        add_ack(SEQ_W'(5), 1'b1);
        add_timeout();
        add_ack(SEQ_W'(199), 1'b1);
        add_ack(SEQ_W'(199), 1'b1);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (event_plan.size() != 0 || have_step || in_if.valid || cfg_if.valid ||
               pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #100_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
